// ----- hw/rtl/pct_pkg.sv -----
// Shared types and constants for the pointer cursor tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pct_pkg;

	// default full-scale range of absolute pointer coordinates
	localparam int unsigned ABS_RANGE_DEF = 65536;

	// entries in the command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 8;

	// register stages of the absolute scaling pipe
	localparam int unsigned SCALE_LAT = 5;

	// pointer request kinds
	typedef enum logic [1:0] {
		ACT_ABS   = 2'd0,
		ACT_REL   = 2'd1,
		ACT_HIDE  = 2'd2,
		ACT_RESET = 2'd3
	} action_t;

	// configuration register indexes
	localparam logic [2:0] REG_SCENE_W  = 3'd0;
	localparam logic [2:0] REG_SCENE_H  = 3'd1;
	localparam logic [2:0] REG_SPRITE_W = 3'd2;
	localparam logic [2:0] REG_SPRITE_H = 3'd3;
	localparam logic [2:0] REG_HOT_X    = 3'd4;
	localparam logic [2:0] REG_HOT_Y    = 3'd5;

	// configuration reset values
	localparam logic [12:0] SCENE_W_RST  = 13'd640;
	localparam logic [12:0] SCENE_H_RST  = 13'd480;
	localparam logic [6:0]  SPRITE_W_RST = 7'd12;
	localparam logic [6:0]  SPRITE_H_RST = 7'd19;
	localparam logic [5:0]  HOT_X_RST    = 6'd0;
	localparam logic [5:0]  HOT_Y_RST    = 6'd0;

	// saturated configuration as seen by the datapath
	typedef struct packed {
		logic [12:0] scene_w;
		logic [12:0] scene_h;
		logic [11:0] scene_w_m1;
		logic [11:0] scene_h_m1;
		logic [6:0]  sprite_w;
		logic [6:0]  sprite_h;
		logic [5:0]  hot_x;
		logic [5:0]  hot_y;
	} cfg_t;

	// one accepted pointer request
	typedef struct packed {
		action_t            action;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} evt_t;

	// classified request with its absolute position already scaled
	typedef struct packed {
		evt_t        evt;
		logic [11:0] abs_x;
		logic [11:0] abs_y;
	} cmd_t;

endpackage

// ----- hw/rtl/pointer_cursor_tracker_top.sv -----
// Pointer cursor tracker: keeps a cursor inside the scene and reports the
// clipped sprite rectangle for each pointer request.
//
// Channels: input requests (action, pos_x, pos_y) on in_valid/in_ready,
// results on out_valid/out_ready, one result per request, in order.
// Configuration: cfg_we/cfg_index/cfg_wdata write scene size, sprite size
// and hotspot; write only while no request is outstanding.
// Path: a request passes the five-stage absolute scaling pipe (split,
// multiply, reciprocal multiply, back-multiply, correction), a queue slot,
// the applied-state stage and the result register.
// Throughput: one request per cycle while credits and out_ready allow; the
// relative-move clamp loops combinationally on the back-end cursor state.
// Stalls: the result register holds while out_ready is low; the front keeps
// taking requests until the 8-entry queue credit is used up, then drops
// in_ready, which depends on registered state only.
// Reset: scene 640x480, sprite 12x19, hotspot 0,0; cursor at 0,0, hidden,
// not seeded, absolute mode clear, no result pending.
// Uses pct_pkg, pct_front, pct_scale, pct_queue and pct_back.
`timescale 1ns / 1ps

module pointer_cursor_tracker_top #(
	parameter int unsigned ABS_RANGE = pct_pkg::ABS_RANGE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [12:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [11:0]        cursor_x,
	output logic [11:0]        cursor_y,
	output logic               shown,
	output logic               absolute_mode,
	output logic               rect_valid,
	output logic [12:0]        rect_x,
	output logic [12:0]        rect_y,
	output logic [6:0]         rect_w,
	output logic [6:0]         rect_h,
	output logic [5:0]         sprite_off_x,
	output logic [5:0]         sprite_off_y
);
	import pct_pkg::*;

	// scene sizes saturate to 1..4096
	function automatic logic [12:0] sat_scene(input logic [12:0] v);
		if (v == 13'd0) begin
			return 13'd1;
		end else if (v > 13'd4096) begin
			return 13'd4096;
		end
		return v;
	endfunction

	// sprite sizes saturate to 1..64
	function automatic logic [6:0] sat_sprite(input logic [6:0] v);
		if (v == 7'd0) begin
			return 7'd1;
		end else if (v > 7'd64) begin
			return 7'd64;
		end
		return v;
	endfunction

	logic [12:0] scene_w_q, scene_h_q;
	logic [6:0]  sprite_w_q, sprite_h_q;
	logic [5:0]  hot_x_q, hot_y_q;
	logic [12:0] scene_w_sat, scene_h_sat;
	logic [12:0] scene_w_m1, scene_h_m1;
	cfg_t        cfg;
	logic        push;
	cmd_t        push_data;
	logic        q_valid;
	cmd_t        q_data;
	logic        pop;

	// configuration registers keep the written bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scene_w_q  <= SCENE_W_RST;
			scene_h_q  <= SCENE_H_RST;
			sprite_w_q <= SPRITE_W_RST;
			sprite_h_q <= SPRITE_H_RST;
			hot_x_q    <= HOT_X_RST;
			hot_y_q    <= HOT_Y_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCENE_W:  scene_w_q  <= cfg_wdata;
				REG_SCENE_H:  scene_h_q  <= cfg_wdata;
				REG_SPRITE_W: sprite_w_q <= cfg_wdata[6:0];
				REG_SPRITE_H: sprite_h_q <= cfg_wdata[6:0];
				REG_HOT_X:    hot_x_q    <= cfg_wdata[5:0];
				REG_HOT_Y:    hot_y_q    <= cfg_wdata[5:0];
				default:      hot_y_q    <= hot_y_q;
			endcase
		end
	end

	// saturated view for the datapath
	assign scene_w_sat = sat_scene(scene_w_q);
	assign scene_h_sat = sat_scene(scene_h_q);
	assign scene_w_m1  = scene_w_sat - 13'd1;
	assign scene_h_m1  = scene_h_sat - 13'd1;

	assign cfg = '{
		scene_w:    scene_w_sat,
		scene_h:    scene_h_sat,
		scene_w_m1: scene_w_m1[11:0],
		scene_h_m1: scene_h_m1[11:0],
		sprite_w:   sat_sprite(sprite_w_q),
		sprite_h:   sat_sprite(sprite_h_q),
		hot_x:      hot_x_q,
		hot_y:      hot_y_q
	};

	pct_front #(.ABS_RANGE(ABS_RANGE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pop       (pop),
		.push      (push),
		.push_data (push_data)
	);

	pct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop)
	);

	pct_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cursor_x      (cursor_x),
		.cursor_y      (cursor_y),
		.shown         (shown),
		.absolute_mode (absolute_mode),
		.rect_valid    (rect_valid),
		.rect_x        (rect_x),
		.rect_y        (rect_y),
		.rect_w        (rect_w),
		.rect_h        (rect_h),
		.sprite_off_x  (sprite_off_x),
		.sprite_off_y  (sprite_off_y)
	);

endmodule

// ----- hw/rtl/pct_scale.sv -----
// Absolute coordinate scaler: pos * (range_m1) / (ABS_RANGE - 1), clamped.
// Fixed five-stage pipe; uses pct_pkg for the default range.
`timescale 1ns / 1ps

module pct_scale #(
	parameter int unsigned ABS_RANGE = pct_pkg::ABS_RANGE_DEF
) (
	input  logic               clk,
	input  logic signed [31:0] pos,
	input  logic [11:0]        range_m1,
	output logic [11:0]        result
);
	import pct_pkg::*;

	// divisor and reciprocal; small inputs keep the product below 2^PW
	localparam int unsigned DIV = ABS_RANGE - 1;
	localparam int unsigned PXW = ($clog2(DIV) < 1) ? 1 : $clog2(DIV);
	localparam int unsigned PW  = PXW + 12;
	localparam int unsigned MW  = 14;
	localparam logic [63:0] RECIP = (64'd1 << PW) / DIV;

	logic           neg_s1, big_s1;
	logic [PXW-1:0] small_s1;
	logic           neg_s2, big_s2;
	logic [PW-1:0]  prod_s2;
	logic           neg_s3, big_s3;
	logic [PW-1:0]  prod_s3;
	logic [11:0]    qest_s3;
	logic           neg_s4, big_s4;
	logic [PW-1:0]  prod_s4;
	logic [PW-1:0]  back_s4;
	logic [11:0]    qest_s4;
	logic [11:0]    result_s5;

	logic [PW+MW-1:0] recip_prod;
	logic [PW-1:0]    rem;
	logic [11:0]      quot;

	// split input: negative clamps to zero, at or past full scale gives the top
	always_ff @(posedge clk) begin
		neg_s1   <= pos[31];
		big_s1   <= !pos[31] && (pos[30:0] >= 31'(DIV));
		small_s1 <= pos[PXW-1:0];
	end

	// product with the scene extent
	always_ff @(posedge clk) begin
		neg_s2  <= neg_s1;
		big_s2  <= big_s1;
		prod_s2 <= {{12{1'b0}}, small_s1} * {{PXW{1'b0}}, range_m1};
	end

	// quotient estimate by reciprocal, at most one low
	assign recip_prod = {{MW{1'b0}}, prod_s2} * {{PW{1'b0}}, MW'(RECIP)};

	always_ff @(posedge clk) begin
		neg_s3  <= neg_s2;
		big_s3  <= big_s2;
		prod_s3 <= prod_s2;
		qest_s3 <= recip_prod[PW +: 12];
	end

	// back-multiply the estimate
	always_ff @(posedge clk) begin
		neg_s4  <= neg_s3;
		big_s4  <= big_s3;
		prod_s4 <= prod_s3;
		qest_s4 <= qest_s3;
		back_s4 <= {{(PW-12){1'b0}}, qest_s3} * PW'(DIV);
	end

	// correction and final select
	assign rem  = prod_s4 - back_s4;
	assign quot = qest_s4 + {11'd0, (rem >= PW'(DIV))};

	always_ff @(posedge clk) begin
		if (neg_s4) begin
			result_s5 <= 12'd0;
		end else if (big_s4) begin
			result_s5 <= range_m1;
		end else begin
			result_s5 <= quot;
		end
	end

	assign result = result_s5;

endmodule

// ----- hw/rtl/pct_front.sv -----
// Front end: accepts pointer requests, scales absolute positions, feeds the queue.
// Uses pct_pkg and two pct_scale pipes; flow control by a credit count.
`timescale 1ns / 1ps

module pct_front #(
	parameter int unsigned ABS_RANGE = pct_pkg::ABS_RANGE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pct_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic               pop,
	output logic               push,
	output pct_pkg::cmd_t      push_data
);
	import pct_pkg::*;

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]        cnt_q;
	logic                 accept;
	logic [SCALE_LAT-1:0] vld_s;
	evt_t                 evt_s [SCALE_LAT];
	logic [11:0]          abs_x;
	logic [11:0]          abs_y;

	// credits cover the scale pipe plus the queue, so a push always fits
	assign in_ready = (cnt_q < CW'(QUEUE_DEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CW'(accept) - CW'(pop);
		end
	end

	// request delay line alongside the scalers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[SCALE_LAT-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		evt_s[0] <= '{action: action_t'(action), pos_x: pos_x, pos_y: pos_y};
		for (int i = 1; i < SCALE_LAT; i++) begin
			evt_s[i] <= evt_s[i-1];
		end
	end

	// absolute position per axis
	pct_scale #(.ABS_RANGE(ABS_RANGE)) u_scale_x (
		.clk      (clk),
		.pos      (pos_x),
		.range_m1 (cfg.scene_w_m1),
		.result   (abs_x)
	);

	pct_scale #(.ABS_RANGE(ABS_RANGE)) u_scale_y (
		.clk      (clk),
		.pos      (pos_y),
		.range_m1 (cfg.scene_h_m1),
		.result   (abs_y)
	);

	// hand the classified request to the queue
	assign push      = vld_s[SCALE_LAT-1];
	assign push_data = '{evt: evt_s[SCALE_LAT-1], abs_x: abs_x, abs_y: abs_y};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("credit count above queue depth");

	a_pop_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("queue pop without an outstanding request");

	a_abs_range: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (abs_x <= cfg.scene_w_m1 && abs_y <= cfg.scene_h_m1))
		else $error("scaled position outside the scene");

endmodule

// ----- hw/rtl/pct_queue.sv -----
// Command queue between front and back ends of the cursor tracker.
// Register-based FIFO of pct_pkg::cmd_t entries.
`timescale 1ns / 1ps

module pct_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pct_pkg::cmd_t push_data,
	output logic          q_valid,
	output pct_pkg::cmd_t q_data,
	input  logic          pop
);
	import pct_pkg::*;

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign q_valid = (count_q != '0);
	assign q_data  = mem_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CW'(QUEUE_DEPTH) || pop))
		else $error("queue push while full");

endmodule

// ----- hw/rtl/pct_back.sv -----
// Back end: applies queued requests to the cursor state, clips the sprite
// rectangle and holds the result register. Uses pct_pkg.
`timescale 1ns / 1ps

module pct_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pct_pkg::cfg_t cfg,
	input  logic          q_valid,
	input  pct_pkg::cmd_t q_data,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [11:0]   cursor_x,
	output logic [11:0]   cursor_y,
	output logic          shown,
	output logic          absolute_mode,
	output logic          rect_valid,
	output logic [12:0]   rect_x,
	output logic [12:0]   rect_y,
	output logic [6:0]    rect_w,
	output logic [6:0]    rect_h,
	output logic [5:0]    sprite_off_x,
	output logic [5:0]    sprite_off_y
);
	import pct_pkg::*;

	// one axis of the clipped sprite rectangle
	typedef struct packed {
		logic        ne;
		logic [12:0] start;
		logic [6:0]  len;
		logic [5:0]  off;
	} span_t;

	// relative move: pointer + (pos - base), clamped to 0..lim
	function automatic logic [11:0] move_clamp(
		input logic [11:0] ptr,
		input logic [31:0] pos,
		input logic [31:0] base,
		input logic [11:0] lim
	);
		logic [32:0] d;
		logic [33:0] s;
		d = {pos[31], pos} - {base[31], base};
		s = {22'd0, ptr} + {d[32], d};
		if (s[33]) begin
			return 12'd0;
		end else if (s[32:0] > {21'd0, lim}) begin
			return lim;
		end
		return s[11:0];
	endfunction

	// sprite span from hotspot position, clipped to 0..scene
	function automatic span_t clip_span(
		input logic [11:0] ptr,
		input logic [5:0]  hot,
		input logic [12:0] scene,
		input logic [6:0]  spr
	);
		logic signed [13:0] tl;
		logic signed [13:0] te;
		logic signed [13:0] lim;
		logic [12:0]        a;
		logic [12:0]        e;
		logic [12:0]        len;
		logic [13:0]        off;
		span_t              sp;
		tl  = $signed({2'b00, ptr}) - $signed({8'd0, hot});
		te  = tl + $signed({7'd0, spr});
		lim = $signed({1'b0, scene});
		a   = tl[13] ? 13'd0 : ((tl > lim) ? scene : tl[12:0]);
		e   = te[13] ? 13'd0 : ((te > lim) ? scene : te[12:0]);
		len = e - a;
		off = {1'b0, a} - tl;
		sp.ne    = (e > a);
		sp.start = a;
		sp.len   = len[6:0];
		sp.off   = off[5:0];
		return sp;
	endfunction

	logic [11:0] pointer_x_q, pointer_y_q;
	logic [31:0] last_raw_x_q, last_raw_y_q;
	logic        seeded_q, abs_latched_q, visible_q;
	logic        pend_q;
	logic        out_valid_q;
	logic [11:0] cursor_x_q, cursor_y_q;
	logic        shown_q, absolute_mode_q, rect_valid_q;
	logic [12:0] rect_x_q, rect_y_q;
	logic [6:0]  rect_w_q, rect_h_q;
	logic [5:0]  sprite_off_x_q, sprite_off_y_q;

	logic        out_free;
	logic        load_s1;
	logic [31:0] base_x, base_y;
	logic [11:0] rel_x, rel_y;
	span_t       span_x, span_y;
	logic        rect_ok;

	// stall chain: result register, then the applied-state stage
	assign out_free = !out_valid_q || out_ready;
	assign load_s1  = !pend_q || out_free;
	assign pop      = q_valid && load_s1;

	// relative move against the stored raw position, seeded on first use
	assign base_x = seeded_q ? last_raw_x_q : q_data.evt.pos_x;
	assign base_y = seeded_q ? last_raw_y_q : q_data.evt.pos_y;
	assign rel_x  = move_clamp(pointer_x_q, q_data.evt.pos_x, base_x, cfg.scene_w_m1);
	assign rel_y  = move_clamp(pointer_y_q, q_data.evt.pos_y, base_y, cfg.scene_h_m1);

	// cursor state update per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_x_q   <= '0;
			pointer_y_q   <= '0;
			last_raw_x_q  <= '0;
			last_raw_y_q  <= '0;
			seeded_q      <= 1'b0;
			abs_latched_q <= 1'b0;
			visible_q     <= 1'b0;
		end else if (pop) begin
			case (q_data.evt.action)
				ACT_ABS: begin
					visible_q     <= 1'b1;
					abs_latched_q <= 1'b1;
					pointer_x_q   <= q_data.abs_x;
					pointer_y_q   <= q_data.abs_y;
				end
				ACT_REL: begin
					visible_q <= 1'b1;
					if (!abs_latched_q) begin
						pointer_x_q  <= rel_x;
						pointer_y_q  <= rel_y;
						last_raw_x_q <= q_data.evt.pos_x;
						last_raw_y_q <= q_data.evt.pos_y;
						seeded_q     <= 1'b1;
					end
				end
				ACT_HIDE: begin
					visible_q <= 1'b0;
				end
				ACT_RESET: begin
					seeded_q      <= 1'b0;
					abs_latched_q <= 1'b0;
				end
				default: begin
					visible_q <= visible_q;
				end
			endcase
		end
	end

	// state holds a result not yet in the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (load_s1) begin
			pend_q <= pop;
		end
	end

	// rectangle clip from the applied state
	assign span_x  = clip_span(pointer_x_q, cfg.hot_x, cfg.scene_w, cfg.sprite_w);
	assign span_y  = clip_span(pointer_y_q, cfg.hot_y, cfg.scene_h, cfg.sprite_h);
	assign rect_ok = span_x.ne && span_y.ne;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pend_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && pend_q) begin
			cursor_x_q      <= pointer_x_q;
			cursor_y_q      <= pointer_y_q;
			shown_q         <= visible_q;
			absolute_mode_q <= abs_latched_q;
			rect_valid_q    <= rect_ok;
			rect_x_q        <= rect_ok ? span_x.start : 13'd0;
			rect_y_q        <= rect_ok ? span_y.start : 13'd0;
			rect_w_q        <= rect_ok ? span_x.len : 7'd0;
			rect_h_q        <= rect_ok ? span_y.len : 7'd0;
			sprite_off_x_q  <= rect_ok ? span_x.off : 6'd0;
			sprite_off_y_q  <= rect_ok ? span_y.off : 6'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign cursor_x      = cursor_x_q;
	assign cursor_y      = cursor_y_q;
	assign shown         = shown_q;
	assign absolute_mode = absolute_mode_q;
	assign rect_valid    = rect_valid_q;
	assign rect_x        = rect_x_q;
	assign rect_y        = rect_y_q;
	assign rect_w        = rect_w_q;
	assign rect_h        = rect_h_q;
	assign sprite_off_x  = sprite_off_x_q;
	assign sprite_off_y  = sprite_off_y_q;

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> pend_q)
		else $error("applied request lost before the result register");

	a_rect_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rect_valid_q) |-> (rect_w_q != 7'd0 && rect_h_q != 7'd0))
		else $error("valid rectangle with zero size");

endmodule
